>>> src/hbm_pkg.sv
// Shared types and register indexes for the heightmap box mean filter.
package hbm_pkg;

    localparam logic [1:0] REG_GRID_WIDTH    = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_WINDOW_RADIUS = 2'd2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage

>>> src/hbm_ram.sv
// Generic single port RAM with registered read.
module hbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

>>> src/hbm_front.sv
// Front end: classify words, handle range errors, queue work for the back end.
module hbm_front #(
    parameter int DW = 9,
    parameter int AW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic          i_action,
    input  logic [AW-1:0] i_col,
    input  logic [AW-1:0] i_row,
    input  logic [15:0]   i_sample,
    input  logic [DW-1:0] i_w,
    input  logic [DW-1:0] i_h,
    input  logic          i_deq,
    output logic          o_q_valid,
    output logic [2*AW+17:0] o_q_word
);
    import hbm_pkg::*;

    // queue word: {err, action, col, row, sample}
    localparam int QW = 2*AW + 18;
    logic [QW-1:0] r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          err;
    logic          acc;

    assign err = (i_action == ACT_READ) &&
                 (({1'b0, i_col} >= i_w) || ({1'b0, i_row} >= i_h));
    assign o_full = (r_cnt == 2'd2);
    assign acc = i_push && !o_full;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_word = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wp] <= {err, i_action, i_col, i_row, i_sample};
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (acc) begin
                r_wp <= ~r_wp;
            end
            if (i_deq && o_q_valid) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, acc} - {1'b0, i_deq && o_q_valid};
        end
    end
endmodule

>>> src/hbm_back.sv
// Back end: write samples, walk the clipped window, divide, hold one result.
module hbm_back #(
    parameter int DW = 9,
    parameter int AW = 8,
    parameter int RW = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  logic [2*AW+17:0] i_q_word,
    output logic          o_deq,
    input  logic [DW-1:0] i_w,
    input  logic [DW-1:0] i_h,
    input  logic [RW-1:0] i_r,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [15:0]   o_mean_height,
    output logic [5:0]    o_window_count,
    output logic          o_range_error
);
    import hbm_pkg::*;

    localparam int CW = 2*RW + 3;
    localparam int SW = 16 + CW;

    t_back_state r_state, n_state;
    logic          q_err, q_act;
    logic [AW-1:0] q_col, q_row;
    logic [15:0]   q_sample;
    logic [AW-1:0] r_c0, r_c1, r_r1, r_ci, r_ri;
    logic [AW:0]   lo_c, lo_r, hi_c, hi_r;
    logic [SW-1:0] r_sum, r_mag, r_rem;
    logic [CW-1:0] r_n;
    logic          r_neg;
    logic [15:0]   r_quo;
    logic [4:0]    r_bit;
    logic          r_full;
    logic [15:0]   r_o_mean;
    logic [5:0]    r_o_cnt;
    logic          r_o_err;
    logic          we;
    logic [2*AW-1:0] addr;
    logic [15:0]   rdata;
    logic          last_cell;
    logic [SW-1:0] trial;
    logic [SW-1:0] last_sum;

    assign {q_err, q_act, q_col, q_row, q_sample} = i_q_word;

    always_comb begin
        lo_c = ({1'b0, q_col} >= {{(AW+1-RW){1'b0}}, i_r}) ?
               {1'b0, q_col} - {{(AW+1-RW){1'b0}}, i_r} : '0;
        lo_r = ({1'b0, q_row} >= {{(AW+1-RW){1'b0}}, i_r}) ?
               {1'b0, q_row} - {{(AW+1-RW){1'b0}}, i_r} : '0;
        hi_c = {1'b0, q_col} + {{(AW+1-RW){1'b0}}, i_r};
        hi_r = {1'b0, q_row} + {{(AW+1-RW){1'b0}}, i_r};
        if ({1'b0, hi_c} >= {1'b0, i_w}) begin
            hi_c = i_w[AW:0] - 1'b1;
        end
        if ({1'b0, hi_r} >= {1'b0, i_h}) begin
            hi_r = i_h[AW:0] - 1'b1;
        end
    end

    assign last_cell = (r_ci == r_c1) && (r_ri == r_r1);
    assign trial = {r_rem[SW-2:0], r_mag[SW-1]};
    assign last_sum = r_sum + {{(SW-16){rdata[15]}}, rdata};

    always_comb begin
        we = 1'b0;
        addr = {r_ri, r_ci};
        o_deq = 1'b0;
        if (r_state == ST_IDLE && i_q_valid) begin
            if (q_act == ACT_WRITE) begin
                we = 1'b1;
                addr = {q_row, q_col};
                o_deq = 1'b1;
            end else if (!r_full) begin
                o_deq = 1'b1;
                addr = {lo_r[AW-1:0], lo_c[AW-1:0]};
            end
        end
    end

    hbm_ram #(.WIDTH(16), .DEPTH(1 << (2*AW))) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(q_sample),
        .o_rdata(rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_deq && q_act == ACT_READ) begin
                    n_state = q_err ? ST_DONE : ST_READ;
                end
            end
            ST_READ: if (last_cell) n_state = ST_LAST;
            ST_LAST: n_state = ST_DIV;
            ST_DIV:  if (r_bit == 5'd0) n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_c0 <= lo_c[AW-1:0];
                r_ci <= lo_c[AW-1:0];
                r_ri <= lo_r[AW-1:0];
                r_c1 <= hi_c[AW-1:0];
                r_r1 <= hi_r[AW-1:0];
                r_sum <= '0;
                r_n <= '0;
                r_quo <= '0;
                r_neg <= q_err;
            end
            ST_READ: begin
                if (r_n != '0) begin
                    r_sum <= r_sum + {{(SW-16){rdata[15]}}, rdata};
                end
                r_n <= r_n + 1'b1;
                if (r_ci == r_c1) begin
                    r_ci <= r_c0;
                    r_ri <= r_ri + 1'b1;
                end else begin
                    r_ci <= r_ci + 1'b1;
                end
            end
            ST_LAST: begin
                // add last read; fold in half divisor for rounding
                r_neg <= last_sum[SW-1];
                r_mag <= (last_sum[SW-1] ? -last_sum : last_sum) +
                         {{(SW-CW+1){1'b0}}, r_n[CW-1:1]};
                r_rem <= '0;
                r_bit <= 5'(SW - 1);
            end
            ST_DIV: begin
                r_mag <= {r_mag[SW-2:0], 1'b0};
                if (trial >= {{(SW-CW){1'b0}}, r_n}) begin
                    r_rem <= trial - {{(SW-CW){1'b0}}, r_n};
                    r_quo <= {r_quo[14:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_quo <= {r_quo[14:0], 1'b0};
                end
                r_bit <= r_bit - 1'b1;
            end
            ST_DONE: begin
                r_o_err <= (r_n == '0);
                r_o_mean <= (r_n == '0) ? 16'd0 : (r_neg ? -r_quo : r_quo);
                r_o_cnt <= 6'(r_n);
            end
            default: ;
        endcase
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_full <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE) begin
                r_full <= 1'b1;
            end else if (i_pop && r_full) begin
                r_full <= 1'b0;
            end
        end
    end

    assign o_empty = !r_full;
    assign o_mean_height = r_o_mean;
    assign o_window_count = r_o_cnt;
    assign o_range_error = r_o_err;
endmodule

>>> src/heightmap_box_mean_filter.sv
// Top level of the heightmap box mean filter.
// A write is stored in the grid RAM when it reaches the head of the input queue
// and the back end is idle. A read holds the back end while it walks a clipped
// window of N samples (up to (2R+1)^2, nine at radius one): it dequeues, issues
// the first RAM read, reads each window sample in turn, adds the last sample,
// runs the bit-serial divider and loads the result register. The single grid
// RAM port and the divider set the rate.
// A two-word queue parts the front end from the back end; a read waits at its
// head while the result register still holds a word that has not been popped.
module heightmap_box_mean_filter #(
    parameter int MAX_DIM = 256,
    parameter int MAX_RADIUS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_action,
    input  logic [$clog2(MAX_DIM)-1:0] i_col,
    input  logic [$clog2(MAX_DIM)-1:0] i_row,
    input  logic signed [15:0] i_sample,
    output logic        empty,
    input  logic        pop,
    output logic signed [15:0] o_mean_height,
    output logic [5:0]  o_window_count,
    output logic        o_range_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    import hbm_pkg::*;

    localparam int AW = $clog2(MAX_DIM);
    localparam int RW = $clog2(MAX_RADIUS + 1);
    localparam int DW = AW + 1;

    logic [8:0] r_w, r_h;
    logic [1:0] r_r;
    logic [DW-1:0] w_eff, h_eff;
    logic [RW-1:0] r_eff;
    logic q_valid, deq;
    logic [2*AW+17:0] q_word;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= 9'd129;
            r_h <= 9'd129;
            r_r <= 2'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GRID_WIDTH:    r_w <= i_cfg_data;
                REG_GRID_HEIGHT:   r_h <= i_cfg_data;
                REG_WINDOW_RADIUS: r_r <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign w_eff = (32'(r_w) > MAX_DIM) ? DW'(MAX_DIM) : DW'(r_w);
    assign h_eff = (32'(r_h) > MAX_DIM) ? DW'(MAX_DIM) : DW'(r_h);
    assign r_eff = (32'(r_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(r_r);

    hbm_front #(.DW(DW), .AW(AW)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_action, .i_col, .i_row, .i_sample,
        .i_w(w_eff), .i_h(h_eff), .i_deq(deq),
        .o_q_valid(q_valid), .o_q_word(q_word)
    );

    hbm_back #(.DW(DW), .AW(AW), .RW(RW)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_word(q_word), .o_deq(deq),
        .i_w(w_eff), .i_h(h_eff), .i_r(r_eff),
        .o_empty(empty), .i_pop(pop),
        .o_mean_height, .o_window_count, .o_range_error
    );
endmodule

>>> src/hbm_checker.sv
// Port-level checker for the heightmap box mean filter, bound to the top level.
module hbm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [15:0] o_mean_height,
    input logic [5:0]  o_window_count,
    input logic        o_range_error
);
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_range_error) |-> (o_mean_height == 16'd0 && o_window_count == 6'd0))
        else $error("range error word carries data");
    a_cnt_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_range_error) |-> (o_window_count != 6'd0))
        else $error("good word has zero count");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_mean_height)))
        else $error("waiting word changed");
endmodule

bind heightmap_box_mean_filter hbm_checker u_chk (.*);

>>> tb/heightmap_box_mean_filter_test.sv
// Self-checking testbench for heightmap_box_mean_filter: table-driven and random words.
`timescale 1ns / 100ps

module heightmap_box_mean_filter_test;
    import hbm_pkg::*;

    localparam int DIM = 256;
    localparam int RAD_MAX = 3;
    localparam int DRAIN_CYCLES = 120;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 175;

    typedef struct packed {
        logic signed [15:0] mean;
        logic [5:0]         count;
        logic               err;
    } t_height_result;

    typedef struct packed {
        logic               action;
        logic [7:0]         col;
        logic [7:0]         row;
        logic signed [15:0] sample;
        logic               typed;
        t_height_result     result;
    } t_table_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic i_action = ACT_WRITE;
    logic [7:0] i_col = '0;
    logic [7:0] i_row = '0;
    logic signed [15:0] i_sample = '0;
    logic empty;
    logic pop = 1'b0;
    logic signed [15:0] o_mean_height;
    logic [5:0] o_window_count;
    logic o_range_error;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = REG_GRID_WIDTH;
    logic [8:0] i_cfg_data = '0;

    logic signed [15:0] heights_ram [DIM*DIM];
    bit planned_cells [DIM*DIM];
    logic [8:0] grid_w = 9'd129;
    logic [8:0] grid_h = 9'd129;
    logic [1:0] radius = 2'd1;
    t_height_result pending_means [$];
    logic typed_now = 1'b0;
    t_height_result typed_result = '0;
    bit quiet = 1'b0;
    int fails = 0;
    int stall_cycles = 0;

    heightmap_box_mean_filter dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_height_result predict_read(logic [7:0] c, logic [7:0] r);
        t_height_result res;
        int w, h, rd, c0, c1, r0, r1, sum, n;
        res = '0;
        w = (grid_w > DIM) ? DIM : grid_w;
        h = (grid_h > DIM) ? DIM : grid_h;
        if (c >= w || r >= h) begin
            res.err = 1'b1;
            return res;
        end
        rd = (radius > RAD_MAX) ? RAD_MAX : radius;
        c0 = (c >= rd) ? c - rd : 0;
        c1 = (c + rd < w - 1) ? c + rd : w - 1;
        r0 = (r >= rd) ? r - rd : 0;
        r1 = (r + rd < h - 1) ? r + rd : h - 1;
        sum = 0;
        n = 0;
        for (int i = c0; i <= c1; i++) begin
            for (int j = r0; j <= r1; j++) begin
                sum += heights_ram[j*DIM + i];
                n++;
            end
        end
        res.mean = 16'((sum >= 0) ? (sum + n/2) / n : -((-sum + n/2) / n));
        res.count = n[5:0];
        return res;
    endfunction

    // find an unwritten cell in the window, if any
    function automatic bit window_hole(logic [7:0] c, logic [7:0] r,
                                       output int hc, output int hr);
        int w, h, c0, c1, r0, r1;
        w = (grid_w > DIM) ? DIM : grid_w;
        h = (grid_h > DIM) ? DIM : grid_h;
        hc = 0;
        hr = 0;
        if (c >= w || r >= h) return 1'b0;
        c0 = (c >= radius) ? c - radius : 0;
        c1 = (c + radius < w - 1) ? c + radius : w - 1;
        r0 = (r >= radius) ? r - radius : 0;
        r1 = (r + radius < h - 1) ? r + radius : h - 1;
        for (int i = c0; i <= c1; i++) begin
            for (int j = r0; j <= r1; j++) begin
                if (!planned_cells[j*DIM + i]) begin
                    hc = i;
                    hr = j;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] near_coord(int dim);
        int base, v;
        case ($urandom_range(0, 4))
            0: base = 0;
            1: base = 255;
            2: base = (dim > DIM) ? DIM - 1 : ((dim > 0) ? dim - 1 : 0);
            3: base = 128;
            default: base = $urandom_range(0, 255);
        endcase
        v = base + $urandom_range(0, 6) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_word(logic act, logic [7:0] c, logic [7:0] r,
                             logic signed [15:0] s, logic typed, t_height_result res);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        if (act == ACT_WRITE) planned_cells[r*DIM + c] = 1'b1;
        push <= 1'b1;
        i_action <= act;
        i_col <= c;
        i_row <= r;
        i_sample <= s;
        typed_now <= typed;
        typed_result <= res;
        do @(posedge i_clk); while (full);
    endtask

    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_means.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_GRID_WIDTH:    grid_w = val;
            REG_GRID_HEIGHT:   grid_h = val;
            REG_WINDOW_RADIUS: radius = val[1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic random_word();
        logic [7:0] c, r;
        int hc, hr;
        if ($urandom_range(0, 99) < 40) begin
            send_word(ACT_WRITE, near_coord(grid_w), near_coord(grid_h),
                      pick_sample(), 1'b0, '0);
        end else begin
            c = near_coord(grid_w);
            r = near_coord(grid_h);
            if (window_hole(c, r, hc, hr))
                send_word(ACT_WRITE, hc[7:0], hr[7:0], pick_sample(), 1'b0, '0);
            else
                send_word(ACT_READ, c, r, '0, 1'b0, '0);
        end
    endtask

    // acceptance of words on both sides
    always @(posedge i_clk) begin
        t_height_result want;
        if (i_rst_n && push && !full) begin
            if (i_action == ACT_WRITE) begin
                heights_ram[i_row*DIM + i_col] = i_sample;
            end else begin
                want = typed_now ? typed_result : predict_read(i_col, i_row);
                pending_means = {pending_means, want};
            end
        end
        if (i_rst_n && pop && !empty) begin
            if (pending_means.size() == 0) begin
                $display("%0t: unexpected result mean %0d count %0d err %0d", $time,
                         o_mean_height, o_window_count, o_range_error);
                fails++;
            end else begin
                want = pending_means.pop_front();
                if (o_mean_height !== want.mean) begin
                    $display("%0t: mean_height expected %0d actual %0d", $time,
                             want.mean, o_mean_height);
                    fails++;
                end
                if (o_window_count !== want.count) begin
                    $display("%0t: window_count expected %0d actual %0d", $time,
                             want.count, o_window_count);
                    fails++;
                end
                if (o_range_error !== want.err) begin
                    $display("%0t: range_error expected %0d actual %0d", $time,
                             want.err, o_range_error);
                    fails++;
                end
            end
        end
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        forever begin
            if (quiet) begin
                pop <= 1'b1;
                @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                pop <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    initial begin
        t_table_row rows [23];
        logic [8:0] phase_cfg [7][3];
        for (int k = 0; k < DIM*DIM; k++) heights_ram[k] = '0;
        rows = '{
            '{ACT_WRITE, 8'd0,   8'd0,   16'sh7FFF, 1'b0, '0},
            '{ACT_WRITE, 8'd1,   8'd0,   16'sh7FFF, 1'b0, '0},
            '{ACT_WRITE, 8'd0,   8'd1,   16'sh7FFF, 1'b0, '0},
            '{ACT_WRITE, 8'd1,   8'd1,   16'sh7FFF, 1'b0, '0},
            '{ACT_READ,  8'd0,   8'd0,   16'sh0000, 1'b1, '{16'sh7FFF, 6'd4, 1'b0}},
            '{ACT_READ,  8'd129, 8'd0,   16'sh0000, 1'b1, '{16'sh0000, 6'd0, 1'b1}},
            '{ACT_READ,  8'd0,   8'd129, 16'sh0000, 1'b1, '{16'sh0000, 6'd0, 1'b1}},
            '{ACT_READ,  8'd255, 8'd255, 16'sh0000, 1'b1, '{16'sh0000, 6'd0, 1'b1}},
            '{ACT_WRITE, 8'd255, 8'd255, 16'sh8000, 1'b0, '0},
            '{ACT_WRITE, 8'd128, 8'd128, 16'sh8000, 1'b0, '0},
            '{ACT_WRITE, 8'd127, 8'd128, 16'sh8000, 1'b0, '0},
            '{ACT_WRITE, 8'd128, 8'd127, 16'sh8000, 1'b0, '0},
            '{ACT_WRITE, 8'd127, 8'd127, 16'sh8000, 1'b0, '0},
            '{ACT_READ,  8'd128, 8'd128, 16'sh0000, 1'b1, '{16'sh8000, 6'd4, 1'b0}},
            '{ACT_WRITE, 8'd0,   8'd0,   16'shFFFF, 1'b0, '0},
            '{ACT_WRITE, 8'd1,   8'd0,   16'shFFFF, 1'b0, '0},
            '{ACT_WRITE, 8'd0,   8'd1,   16'sh0000, 1'b0, '0},
            '{ACT_WRITE, 8'd1,   8'd1,   16'sh0000, 1'b0, '0},
            '{ACT_READ,  8'd0,   8'd0,   16'sh0000, 1'b0, '0},
            '{ACT_WRITE, 8'd0,   8'd0,   16'sh0000, 1'b0, '0},
            '{ACT_WRITE, 8'd1,   8'd0,   16'sh0000, 1'b0, '0},
            '{ACT_WRITE, 8'd1,   8'd1,   16'sh0002, 1'b0, '0},
            '{ACT_READ,  8'd0,   8'd0,   16'sh0000, 1'b0, '0}
        };
        phase_cfg = '{
            '{9'd256, 9'd256, 9'd3},
            '{9'd1,   9'd1,   9'd0},
            '{9'd0,   9'd7,   9'd2},
            '{9'd511, 9'd300, 9'd1},
            '{9'd200, 9'd17,  9'd2},
            '{9'd5,   9'd0,   9'd3},
            '{9'd256, 9'd256, 9'd0}
        };
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[k])
            send_word(rows[k].action, rows[k].col, rows[k].row, rows[k].sample,
                      rows[k].typed, rows[k].result);
        for (int p = 0; p < 7; p++) begin
            drain();
            write_reg(REG_GRID_WIDTH, phase_cfg[p][0]);
            write_reg(REG_GRID_HEIGHT, phase_cfg[p][1]);
            write_reg(REG_WINDOW_RADIUS, phase_cfg[p][2]);
            if (p == 6) quiet = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 3 && k == PHASE_ITEMS/2) begin
                    push <= 1'b0;
                    do @(posedge i_clk); while (pending_means.size() != 0);
                end
                random_word();
            end
        end
        drain();
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
src/hbm_pkg.sv
src/hbm_ram.sv
src/hbm_front.sv
src/hbm_back.sv
src/heightmap_box_mean_filter.sv
src/hbm_checker.sv
tb/heightmap_box_mean_filter_test.sv
